/* design/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types, widths and coefficients of the fourth-order Bessel low-pass
// filter: sample format, Q2.30 coefficient tables and the result record.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // Sample format is signed Q16.16, coefficients are signed Q2.30.
    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 32;
    localparam int FRAC_SHIFT = 30;
    localparam int HIST_DEPTH = 4;
    localparam int FF_TAPS    = HIST_DEPTH + 1;

    // An exact product, then room for the sum of all nine products.
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int RND_W  = ACC_W - FRAC_SHIFT;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef t_sample                    t_hist [HIST_DEPTH];

    typedef struct packed {
        t_sample filtered;
        logic    saturated;
    } t_result;

    // Feed-forward taps b1..b5 for x[n] .. x[n-4].
    localparam t_coef FF_COEF [FF_TAPS] = '{
        t_coef'(16516117),
        t_coef'(66064467),
        t_coef'(99096700),
        t_coef'(66064467),
        t_coef'(16516117)
    };

    // Feedback taps, already negated (-a2 .. -a5) for y[n-1] .. y[n-4].
    localparam t_coef FB_COEF [HIST_DEPTH] = '{
        t_coef'(1570965274),
        -t_coef'(1077273666),
        t_coef'(366658726),
        -t_coef'(50866376)
    };

    // Half an output LSB for round to nearest.
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        {{(ACC_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};

    localparam t_sample SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

/* design/bsl_if.sv */
// ----------------------------------------------------------------------------
// bsl_in_if / bsl_out_if
// Valid/ready channels of the Bessel filter: one input sample per request,
// one filtered sample with its saturation flag per request.
// ----------------------------------------------------------------------------
interface bsl_in_if;
    import bsl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bsl_out_if;
    import bsl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample filtered;
    logic    saturated;

    modport source (output valid, output filtered, output saturated, input ready);
    modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

/* design/bsl_history.sv */
// ----------------------------------------------------------------------------
// bsl_history
// Delay lines of the filter: the last four input samples and the last four
// output samples, cleared at reset and shifted once per processed sample.
// ----------------------------------------------------------------------------
module bsl_history (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  bsl_pkg::t_sample i_x,
    input  bsl_pkg::t_sample i_y,
    output bsl_pkg::t_hist   o_x_hist,
    output bsl_pkg::t_hist   o_y_hist
);
    import bsl_pkg::*;

    t_hist r_x_hist;
    t_hist r_y_hist;

    // Shift both lines; the newest sample enters at index zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_x_hist[i] <= '0;
                r_y_hist[i] <= '0;
            end
        end else if (i_shift) begin
            r_x_hist[0] <= i_x;
            r_y_hist[0] <= i_y;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_x_hist[i] <= r_x_hist[i-1];
                r_y_hist[i] <= r_y_hist[i-1];
            end
        end
    end

    assign o_x_hist = r_x_hist;
    assign o_y_hist = r_y_hist;

endmodule

/* design/bsl_datapath.sv */
// ----------------------------------------------------------------------------
// bsl_datapath
// One pass of the direct form I filter: nine constant multiplies, an exact
// sum, round to nearest and saturation to the sample range.
// ----------------------------------------------------------------------------
module bsl_datapath (
    input  bsl_pkg::t_sample i_x,
    input  bsl_pkg::t_hist   i_x_hist,
    input  bsl_pkg::t_hist   i_y_hist,
    output bsl_pkg::t_result o_result
);
    import bsl_pkg::*;

    t_sample                    x_taps  [FF_TAPS];
    logic signed [PROD_W-1:0]   ff_prod [FF_TAPS];
    logic signed [PROD_W-1:0]   fb_prod [HIST_DEPTH];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    biased;
    logic signed [ACC_W-1:0]    shifted;
    logic signed [RND_W-1:0]    rounded;
    logic [RND_W-SAMPLE_W:0]    upper;
    logic                       fits;

    // Products are exact: both operands are sign-extended to full width.
    always_comb begin
        x_taps[0] = i_x;
        for (int i = 1; i < FF_TAPS; i++) begin
            x_taps[i] = i_x_hist[i-1];
        end
        for (int i = 0; i < FF_TAPS; i++) begin
            ff_prod[i] = PROD_W'(x_taps[i]) * PROD_W'(FF_COEF[i]);
        end
        for (int i = 0; i < HIST_DEPTH; i++) begin
            fb_prod[i] = PROD_W'(i_y_hist[i]) * PROD_W'(FB_COEF[i]);
        end
    end

    // Accumulate all taps without intermediate truncation.
    always_comb begin
        acc = '0;
        for (int i = 0; i < FF_TAPS; i++) begin
            acc = acc + ACC_W'(ff_prod[i]);
        end
        for (int i = 0; i < HIST_DEPTH; i++) begin
            acc = acc + ACC_W'(fb_prod[i]);
        end
    end

    // Round to nearest with ties toward plus infinity, then clip.
    always_comb begin
        biased  = acc + ROUND_BIAS;
        shifted = biased >>> FRAC_SHIFT;
        rounded = shifted[RND_W-1:0];
        upper   = rounded[RND_W-1:SAMPLE_W-1];
        fits    = (&upper) || !(|upper);
        if (fits) begin
            o_result.filtered  = rounded[SAMPLE_W-1:0];
            o_result.saturated = 1'b0;
        end else begin
            o_result.filtered  = rounded[RND_W-1] ? SAT_MIN : SAT_MAX;
            o_result.saturated = 1'b1;
        end
    end

endmodule

/* design/bessel_iir_lowpass.sv */
// ----------------------------------------------------------------------------
// bessel_iir_lowpass
// Fourth-order Bessel low-pass IIR filter, direct form I, Q16.16 samples and
// fixed Q2.30 coefficients, rounded and saturated output.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on i_in, one request per signed Q16.16 sample. Each sample
// produces exactly one request on o_out carrying the filtered sample and a
// flag that is set when the result was clipped to the 32-bit range.
// An accepted sample lands in an input register; when the output register
// is free or emptying, the filter pass (nine multiplies, sum, rounding,
// saturation) is written into the output register and both delay lines
// shift. Throughput is one sample per cycle while the receiver does not
// stall. The feedback through the output delay line closes within one
// combinational pass, which sets the clock rate.
// Reset clears both delay lines to zero and empties the input and output
// registers. When the receiver stalls, the result waits in the output
// register, one more sample is still taken into the input register, and
// i_in.ready then drops until the output moves again.
// ----------------------------------------------------------------------------
module bessel_iir_lowpass (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bsl_in_if.sink           i_in,
    bsl_out_if.source        o_out
);
    import bsl_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_sample r_sample;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_result result;
    t_hist   x_hist;
    t_hist   y_hist;
    logic    accept;
    logic    advance;

    // Handshake: the pass runs when the output register is free or emptying.
    always_comb begin
        advance     = r_in_valid && (!r_out_valid || o_out.ready);
        accept      = i_in.valid && i_in.ready;
        n_in_valid  = accept || (r_in_valid && !advance);
        n_out_valid = advance || (r_out_valid && !o_out.ready);
    end

    assign i_in.ready = !r_in_valid || advance;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_in.sample;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    bsl_datapath u_datapath (
        .i_x      (r_sample),
        .i_x_hist (x_hist),
        .i_y_hist (y_hist),
        .o_result (result)
    );

    bsl_history u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (advance),
        .i_x      (r_sample),
        .i_y      (result.filtered),
        .o_x_hist (x_hist),
        .o_y_hist (y_hist)
    );

    assign o_out.valid     = r_out_valid;
    assign o_out.filtered  = r_result.filtered;
    assign o_out.saturated = r_result.saturated;

endmodule

/* tb/sv/bessel_iir_lowpass_tb.sv */
// ----------------------------------------------------------------------------
// bessel_iir_lowpass_tb
// Self-checking bench for the fourth-order Bessel low-pass filter. A short
// table of directed samples runs first. Random segments of full-range noise,
// long extreme steps that drive the output into clipping, and small values
// follow. A local direct form I predictor with its own delay lines computes
// every filtered sample and saturation flag. Both channels idle at random.
// ----------------------------------------------------------------------------
module bessel_iir_lowpass_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsl_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int MAX_GAP      = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;

    // Q2.30 taps: b1..b5 for x[n]..x[n-4], then the negated a2..a5.
    localparam int FEED_FWD [5] = '{16516117, 66064467, 99096700, 66064467, 16516117};
    localparam int FEED_BACK [4] = '{1570965274, -1077273666, 366658726, -50866376};

    localparam t_sample MAX_SAMPLE = 32'sh7FFF_FFFF;
    localparam t_sample MIN_SAMPLE = 32'sh8000_0000;

    typedef logic signed [79:0] t_wide;

    typedef struct {
        t_sample sample;
        bit      typed;
        t_sample want;
        bit      want_sat;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    bsl_in_if  in_ch ();
    bsl_out_if out_ch ();

    bessel_iir_lowpass dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: x[n-1]..x[n-4] and y[n-1]..y[n-4].
    t_sample x_hist [4];
    t_sample y_hist [4];

    t_result expected_outputs [$];
    int      error_count;
    int      cycle_count;

    // Typed expectation that travels with the request on the input channel.
    bit      row_typed;
    t_sample row_want;
    bit      row_want_sat;

    t_result predicted;
    t_result observed;

    // Directed samples: reset state, extremes, unit steps and a full swing.
    t_stim_row directed_rows [24] = '{
        '{32'sd0,          1'b1, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b1, 32'sd33032234, 1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{32'sd0,          1'b0, 32'sd0,        1'b0},
        '{-32'sd1,         1'b0, 32'sd0,        1'b0},
        '{32'sd1,          1'b0, 32'sd0,        1'b0},
        '{32'sh5555_5555,  1'b0, 32'sd0,        1'b0},
        '{32'shAAAA_AAAA,  1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MAX_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0},
        '{MIN_SAMPLE,      1'b0, 32'sd0,        1'b0}
    };

    // One filter pass: exact products, round half up, clip, shift delay lines.
    function automatic t_result filter_step(t_sample x);
        t_wide   acc;
        t_wide   rounded;
        t_result res;
        acc = t_wide'(x) * t_wide'(FEED_FWD[0]);
        for (int i = 0; i < 4; i++) begin
            acc += t_wide'(x_hist[i]) * t_wide'(FEED_FWD[i + 1]);
            acc += t_wide'(y_hist[i]) * t_wide'(FEED_BACK[i]);
        end
        rounded = (acc + (t_wide'(1) <<< 29)) >>> 30;
        if (rounded > t_wide'(MAX_SAMPLE)) begin
            res = '{MAX_SAMPLE, 1'b1};
        end else if (rounded < t_wide'(MIN_SAMPLE)) begin
            res = '{MIN_SAMPLE, 1'b1};
        end else begin
            res = '{t_sample'(rounded), 1'b0};
        end
        for (int i = 3; i > 0; i--) begin
            x_hist[i] = x_hist[i - 1];
            y_hist[i] = y_hist[i - 1];
        end
        x_hist[0] = x;
        y_hist[0] = res.filtered;
        return res;
    endfunction

    // Count a failure and describe only the first few.
    task automatic note_failure(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // Drive one sample request after a random gap (none when calm) and wait for its acceptance.
    task automatic send_sample(t_sample s, bit typed, t_sample want, bit want_sat,
                               bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid  = 1'b1;
        in_ch.sample = s;
        row_typed    = typed;
        row_want     = want;
        row_want_sat = want_sat;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Known values from time zero, then one reset at the start of the run.
    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        row_typed    = 1'b0;
        row_want     = '0;
        row_want_sat = 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        for (int i = 0; i < 4; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: a random stall before each result, with calm stretches.
    initial begin : receiver
        int gap;
        int stretch;
        bit calm;
        calm    = 1'b0;
        stretch = 0;
        @(posedge i_rst_n);
        forever begin
            if (stretch == 0) begin
                calm    = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(20, 80);
            end
            stretch--;
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            repeat (gap) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Monitor: predict each accepted sample and check each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predicted = filter_step(in_ch.sample);
                if (row_typed) begin
                    predicted = '{row_want, row_want_sat};
                end
                expected_outputs.push_back(predicted);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_outputs.size() == 0) begin
                    note_failure($sformatf("result %0d/%0b with no sample pending",
                                           out_ch.filtered, out_ch.saturated));
                end else begin
                    predicted = expected_outputs.pop_front();
                    observed  = '{out_ch.filtered, out_ch.saturated};
                    if (observed.filtered !== predicted.filtered) begin
                        note_failure($sformatf("filtered expected %0d got %0d",
                                               predicted.filtered, observed.filtered));
                    end
                    if (observed.saturated !== predicted.saturated) begin
                        note_failure($sformatf("saturated expected %0b got %0b",
                                               predicted.saturated, observed.saturated));
                    end
                end
            end
        end
    end

    // Sender: directed table, then random segments, then drain and verdict.
    initial begin : sender
        int      sent;
        int      seg_len;
        int      seg_kind;
        bit      calm;
        bit      paused;
        t_sample level;
        t_sample s;
        sent   = 0;
        paused = 1'b0;
        @(posedge i_rst_n);

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].sample, directed_rows[i].typed,
                        directed_rows[i].want, directed_rows[i].want_sat,
                        $urandom_range(0, 1));
        end

        // Let the pipeline empty completely before the random part.
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        row_typed   = 1'b0;
        wait (expected_outputs.size() == 0);

        while (sent < RANDOM_ITEMS) begin
            seg_kind = $urandom_range(0, 9);
            seg_len  = $urandom_range(1, 40);
            calm     = ($urandom_range(0, 3) == 0);
            if (seg_kind >= 7) begin
                // Long steps to the rails settle and then overshoot into clipping.
                seg_len = $urandom_range(4, 30);
                level   = $urandom_range(0, 1) ? MAX_SAMPLE : MIN_SAMPLE;
                if ($urandom_range(0, 3) == 0) begin
                    level = level ^ t_sample'($urandom_range(0, 255));
                end
            end
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                case (seg_kind)
                    0, 1, 2, 3: begin
                        s = t_sample'($urandom);
                    end
                    4, 5: begin
                        s = t_sample'($signed($urandom_range(0, 131072)) - 65536);
                    end
                    6: begin
                        case ($urandom_range(0, 3))
                            0: s = '0;
                            1: s = -32'sd1;
                            2: s = 32'sd1;
                            default: s = $urandom_range(0, 1) ? MAX_SAMPLE : MIN_SAMPLE;
                        endcase
                    end
                    default: begin
                        s = level;
                    end
                endcase
                send_sample(s, 1'b0, '0, 1'b0, calm);
                sent++;
            end
            // Once, midway, hold off until every pending result has come back.
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                wait (expected_outputs.size() == 0);
            end
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        wait (expected_outputs.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_outputs.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_outputs.size()));
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
